@@ rtl/crc16fb_pkg.sv @@
package crc16fb_pkg;

   localparam int MAX_FRAME_BYTES = 4096;
   localparam int MIN_FRAME_BYTES = 64;

   localparam int CFG_W    = 13;
   localparam int LEN_W    = 16;
   localparam int CRC_W    = 16;
   localparam int BYTE_W   = 8;
   localparam int STATUS_W = 2;

   localparam logic [CRC_W-1:0] CRC_POLY      = 16'h1021;
   localparam logic [CRC_W-1:0] CRC_HIGH_MASK = 16'hff00;
   localparam logic [CRC_W-1:0] CRC_LOW_MASK  = 16'h00ff;

   localparam logic [0:0] CSR_FRAME_SIZE = 1'b0;
   localparam logic [0:0] CSR_PAD_BYTE   = 1'b1;

   localparam logic [CFG_W-1:0]  FRAME_SIZE_RESET = 13'd64;
   localparam logic [BYTE_W-1:0] PAD_BYTE_RESET   = 8'd127;

   localparam logic [0:0] MODE_BUILD = 1'b0;
   localparam logic [0:0] MODE_CHECK = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_LENGTH   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_CRC_FAIL = 2'd2;

   typedef struct packed {
      logic [BYTE_W-1:0]   out_byte;
      logic                last;
      logic [STATUS_W-1:0] status;
   } rsp_item_type;

   function automatic logic [CRC_W-1:0] crc_add(logic [CRC_W-1:0] crc, logic [BYTE_W-1:0] b);
      logic [CRC_W-1:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[CRC_W-1] ? ({c[CRC_W-2:0], 1'b0} ^ CRC_POLY) : {c[CRC_W-2:0], 1'b0};
      end
      return c;
   endfunction

endpackage

@@ rtl/crc16_frame_builder_checker.sv @@
// Fixed-size CRC-16 frame engine (poly 0x1021, init 0, not reflected). With req_mode 0 it
// takes the body bytes of a frame and returns the frame: the 16-bit big-endian length in
// body bytes 1 and 2 sets where padding with the pad byte begins, and the CRC follows high
// byte first; a length above frame size minus two yields a single last response with
// status 1. With req_mode 1 it takes a whole frame and returns one last response with
// status 0 (ok), 1 (length zero or too large) or 2 (CRC mismatch). Frame size is clamped
// to 64..MAX_FRAME_BYTES. One request is taken per cycle while req_stall is low; in build
// mode with a valid length the third body byte and the final body byte each produce three
// responses, which drain one per cycle while rsp_stall is low from a three-entry buffer;
// no request is taken until its last entry pops. Responses are registered and appear in
// the cycle after acceptance. Write the csr registers only while the block is idle.
module crc16_frame_builder_checker #(
   parameter int MAX_FRAME_BYTES = crc16fb_pkg::MAX_FRAME_BYTES
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write,
   input  logic [0:0]                         csr_index,
   input  logic [crc16fb_pkg::CFG_W-1:0]      csr_data,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_mode,
   input  logic [crc16fb_pkg::BYTE_W-1:0]     req_data_byte,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [crc16fb_pkg::BYTE_W-1:0]     rsp_out_byte,
   output logic                               rsp_last,
   output logic [crc16fb_pkg::STATUS_W-1:0]   rsp_status
);

   localparam int POS_W = $clog2(MAX_FRAME_BYTES);
   localparam int LEN_W = crc16fb_pkg::LEN_W;
   localparam int CRC_W = crc16fb_pkg::CRC_W;
   localparam int BW    = crc16fb_pkg::BYTE_W;
   localparam logic [LEN_W-1:0] MAX_SIZE = LEN_W'(MAX_FRAME_BYTES);
   localparam logic [LEN_W-1:0] MIN_SIZE = LEN_W'(crc16fb_pkg::MIN_FRAME_BYTES);

   logic [crc16fb_pkg::CFG_W-1:0] frame_size_ff;
   logic [BW-1:0]                 pad_byte_ff;

   logic [POS_W-1:0] position_ff, position_in;
   logic [CRC_W-1:0] crc_ff, crc_in;
   logic [LEN_W-1:0] length_ff, length_in;
   logic             length_error_ff, length_error_in;
   logic [BW-1:0]    crc_high_ff, crc_high_in;
   logic [BW-1:0]    header0_ff, header0_in;
   logic [BW-1:0]    header1_ff, header1_in;

   crc16fb_pkg::rsp_item_type slot_ff [3];
   crc16fb_pkg::rsp_item_type slot_in [3];
   logic [1:0] count_ff, count_in;

   crc16fb_pkg::rsp_item_type res [3];
   logic [1:0] res_n;

   logic             accept, pop;
   logic [LEN_W-1:0] fs_raw, eff_size, pos16, len_now;
   logic             err_now, is_final;
   logic [BW-1:0]    v0, v1, v2;
   logic [CRC_W-1:0] c0, c1, c2;
   logic [LEN_W-1:0] received;

   assign pop       = (count_ff != 2'd0) && !rsp_stall;
   assign req_stall = !((count_ff == 2'd0) || ((count_ff == 2'd1) && !rsp_stall));
   assign accept    = req_valid && !req_stall;

   assign rsp_valid    = (count_ff != 2'd0);
   assign rsp_out_byte = slot_ff[0].out_byte;
   assign rsp_last     = slot_ff[0].last;
   assign rsp_status   = slot_ff[0].status;

   // frame size clamp
   assign fs_raw   = LEN_W'(frame_size_ff);
   assign eff_size = (fs_raw < MIN_SIZE) ? MIN_SIZE : ((fs_raw > MAX_SIZE) ? MAX_SIZE : fs_raw);
   assign pos16    = LEN_W'(position_ff);

   always_comb begin
      position_in     = position_ff;
      crc_in          = crc_ff;
      length_in       = length_ff;
      length_error_in = length_error_ff;
      crc_high_in     = crc_high_ff;
      header0_in      = header0_ff;
      header1_in      = header1_ff;
      for (int i = 0; i < 3; i++) begin
         res[i] = '{out_byte: '0, last: 1'b0, status: crc16fb_pkg::STATUS_OK};
      end
      res_n    = 2'd0;
      len_now  = length_ff;
      err_now  = length_error_ff;
      is_final = 1'b0;
      v0 = '0; v1 = '0; v2 = '0;
      c0 = '0; c1 = '0; c2 = '0;
      received = {crc_high_ff, req_data_byte};

      if (pos16 == LEN_W'(0)) begin
         header0_in = req_data_byte;
      end
      if (pos16 == LEN_W'(1)) begin
         header1_in = req_data_byte;
      end
      if (pos16 == LEN_W'(2)) begin
         len_now = {header1_ff, req_data_byte};
         if (req_mode == crc16fb_pkg::MODE_BUILD) begin
            err_now = (len_now > eff_size - LEN_W'(2));
         end else begin
            err_now = (len_now == '0) || (len_now > eff_size - LEN_W'(2));
         end
         length_in       = len_now;
         length_error_in = err_now;
      end

      if (req_mode == crc16fb_pkg::MODE_BUILD) begin
         is_final = (pos16 >= eff_size - LEN_W'(3));
         if ((pos16 >= LEN_W'(2)) && !err_now) begin
            if (pos16 == LEN_W'(2)) begin
               // header bytes released once the length is known
               v0 = (len_now == '0) ? pad_byte_ff : header0_ff;
               v1 = (len_now <= LEN_W'(1)) ? pad_byte_ff : header1_ff;
               v2 = (len_now <= LEN_W'(2)) ? pad_byte_ff : req_data_byte;
               c0 = crc16fb_pkg::crc_add(crc_ff, v0);
               c1 = crc16fb_pkg::crc_add(c0, v1);
               c2 = crc16fb_pkg::crc_add(c1, v2);
               res[0].out_byte = v0;
               res[1].out_byte = v1;
               res[2].out_byte = v2;
               res_n  = 2'd3;
               crc_in = c2;
            end else begin
               v0 = (pos16 >= len_now) ? pad_byte_ff : req_data_byte;
               c0 = crc16fb_pkg::crc_add(crc_ff, v0);
               res[0].out_byte = v0;
               res_n  = 2'd1;
               crc_in = c0;
               if (is_final) begin
                  res[1].out_byte = BW'((c0 & crc16fb_pkg::CRC_HIGH_MASK) >> 8);
                  res[2].out_byte = BW'(c0 & crc16fb_pkg::CRC_LOW_MASK);
                  res[2].last     = 1'b1;
                  res_n = 2'd3;
               end
            end
         end else if (is_final) begin
            res[0].last   = 1'b1;
            res[0].status = crc16fb_pkg::STATUS_LENGTH;
            res_n = 2'd1;
         end
         if (!is_final) begin
            position_in = position_ff + POS_W'(1);
         end
      end else begin
         is_final = (pos16 >= eff_size - LEN_W'(1));
         if (is_final) begin
            res[0].last = 1'b1;
            if (received != crc_ff) begin
               res[0].status = crc16fb_pkg::STATUS_CRC_FAIL;
            end else if (length_error_ff) begin
               res[0].status = crc16fb_pkg::STATUS_LENGTH;
            end
            res_n = 2'd1;
         end else begin
            if (pos16 == eff_size - LEN_W'(2)) begin
               crc_high_in = req_data_byte;
            end else begin
               crc_in = crc16fb_pkg::crc_add(crc_ff, req_data_byte);
            end
            position_in = position_ff + POS_W'(1);
         end
      end

      if (is_final) begin
         position_in     = '0;
         crc_in          = '0;
         length_error_in = 1'b0;
      end
   end

   // response buffer, slot 0 is presented
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         slot_in[i] = slot_ff[i];
      end
      count_in = count_ff;
      if (pop) begin
         slot_in[0] = slot_ff[1];
         slot_in[1] = slot_ff[2];
         count_in   = count_ff - 2'd1;
      end
      if (accept) begin
         for (int i = 0; i < 3; i++) begin
            slot_in[i] = res[i];
         end
         count_in = res_n;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_size_ff   <= crc16fb_pkg::FRAME_SIZE_RESET;
         pad_byte_ff     <= crc16fb_pkg::PAD_BYTE_RESET;
         position_ff     <= '0;
         crc_ff          <= '0;
         length_ff       <= '0;
         length_error_ff <= 1'b0;
         crc_high_ff     <= '0;
         count_ff        <= 2'd0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               crc16fb_pkg::CSR_FRAME_SIZE: frame_size_ff <= csr_data;
               crc16fb_pkg::CSR_PAD_BYTE:   pad_byte_ff   <= csr_data[BW-1:0];
               default: ;
            endcase
         end
         if (accept) begin
            position_ff     <= position_in;
            crc_ff          <= crc_in;
            length_ff       <= length_in;
            length_error_ff <= length_error_in;
            crc_high_ff     <= crc_high_in;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         header0_ff <= header0_in;
         header1_ff <= header1_in;
      end
      for (int i = 0; i < 3; i++) begin
         slot_ff[i] <= slot_in[i];
      end
   end

`ifndef SYNTHESIS
   a_frame_start_clean: assert property (@(posedge clock) disable iff (reset)
      (position_ff == '0) |-> ((crc_ff == '0) && !length_error_ff))
      else $error("frame start with stale crc or length error");

   a_error_byte_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last && (rsp_status != crc16fb_pkg::STATUS_OK)) |-> (rsp_out_byte == '0))
      else $error("error response carries a nonzero byte");

   a_status_only_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> (rsp_status == crc16fb_pkg::STATUS_OK))
      else $error("status set on a response that is not last");

   a_burst_fill: assert property (@(posedge clock) disable iff (reset)
      (accept && (res_n == 2'd3)) |=> (count_ff == 2'd3))
      else $error("three-response request not fully buffered");
`endif

endmodule
